@@ rtl/core/mvr_pkg.sv @@
// Shared types, constants and helpers for the multigrid volume restriction block.
package mvr_pkg;

  localparam int unsigned CFG_W       = 8;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CP_W        = 7;
  localparam int unsigned CELL_W      = 10;
  localparam int unsigned FI_W        = 7;
  localparam int unsigned MAX_CELLS_I = 128;
  localparam int unsigned CMP_W       = 12;
  localparam int unsigned QDEPTH      = 8;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FINE_J   = 3'd0,
    REG_FINE_K   = 3'd1,
    REG_FINE_I   = 3'd2,
    REG_COARSE_J = 3'd3,
    REG_COARSE_K = 3'd4,
    REG_COARSE_I = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    SEL_MAIN   = 4'b0001,
    SEL_GHOSTJ = 4'b0010,
    SEL_GHOSTK = 4'b0100,
    SEL_CORNER = 4'b1000
  } res_sel_e;

  typedef struct packed {
    logic [CP_W-1:0] cpj;
    logic [CP_W-1:0] cpk;
    logic [CP_W-1:0] cpi;
  } coarse_cfg_t;

  typedef struct packed {
    logic j_odd;
    logic row_go;
    logic k_odd;
    logic plane_go;
    logic i_odd;
    logic emit;
  } step_flags_t;

  typedef struct packed {
    logic [CP_W-1:0] jj;
    logic [CP_W-1:0] kk;
    logic [CP_W-1:0] ii;
    logic            gj;
    logic            gk;
  } res_tag_t;

  function automatic logic [CELL_W-1:0] cell_count(input logic [CFG_W-1:0]  pts,
                                                   input logic [CELL_W-1:0] maxc);
    logic [CELL_W-1:0] c;
    c = (pts >= CFG_W'(2)) ? (CELL_W'(pts) - CELL_W'(1)) : CELL_W'(1);
    return (c > maxc) ? maxc : c;
  endfunction

endpackage

@@ rtl/core/multigrid_volume_restrict.sv @@
// Top level of the 2x2x2 box-sum restriction of fine cell volumes onto a coarse mesh.
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------------------
//   in      | in_valid_i / in_stall_o  | fine_volume_i
//   out     | out_valid_o / out_stall_i| coarse_volume_o, coarse_j_o/k_o/i_o, last_of_run_o
//   cfg     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One fine item per cycle while in_stall_o is low; the row and plane memories each take one
// read and one write a cycle. Coarse values pass row and plane stage registers to the queue.
// Each coarse value leaves as one to four result items, one per cycle without out_stall_i.
// in_stall_o rises when the 8-entry queue plus values still in the pipe would fill it.
// After reset the block accepts at once; the memories need no clearing pass.
module multigrid_volume_restrict #(
  parameter int unsigned MAX_COARSE_J = 64,
  parameter int unsigned MAX_COARSE_K = 64,
  parameter int unsigned VOLUME_BITS  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mvr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mvr_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [VOLUME_BITS-1:0]         fine_volume_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [VOLUME_BITS+2:0]         coarse_volume_o,
  output logic [mvr_pkg::CP_W-1:0]       coarse_j_o,
  output logic [mvr_pkg::CP_W-1:0]       coarse_k_o,
  output logic [mvr_pkg::CP_W-1:0]       coarse_i_o,
  output logic                           last_of_run_o
);
  import mvr_pkg::*;

  localparam int unsigned FJ_W = $clog2(2 * MAX_COARSE_J);
  localparam int unsigned FK_W = $clog2(2 * MAX_COARSE_K);

  logic                   acc;
  logic [FJ_W-1:0]        jc;
  logic [FK_W-1:0]        kc;
  logic [FI_W-1:0]        ic;
  step_flags_t            flags;
  coarse_cfg_t            ccfg;
  logic                   push;
  logic [VOLUME_BITS+2:0] push_vol;
  res_tag_t               push_tag;
  logic [1:0]             pending;

  assign acc = in_valid_i & ~in_stall_o;

  mvr_seq #(
    .MAX_COARSE_J (MAX_COARSE_J),
    .MAX_COARSE_K (MAX_COARSE_K)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .jc_o        (jc),
    .kc_o        (kc),
    .ic_o        (ic),
    .flags_o     (flags),
    .ccfg_o      (ccfg)
  );

  mvr_accum #(
    .MAX_COARSE_J (MAX_COARSE_J),
    .MAX_COARSE_K (MAX_COARSE_K),
    .VOLUME_BITS  (VOLUME_BITS)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .fine_volume_i (fine_volume_i),
    .flags_i       (flags),
    .jc_i          (jc),
    .kc_i          (kc),
    .ic_i          (ic),
    .ccfg_i        (ccfg),
    .push_o        (push),
    .push_vol_o    (push_vol),
    .push_tag_o    (push_tag),
    .pending_o     (pending)
  );

  mvr_outq #(
    .VOLUME_BITS (VOLUME_BITS)
  ) u_outq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .push_vol_i      (push_vol),
    .push_tag_i      (push_tag),
    .pending_i       (pending),
    .ccfg_i          (ccfg),
    .stall_o         (in_stall_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .coarse_volume_o (coarse_volume_o),
    .coarse_j_o      (coarse_j_o),
    .coarse_k_o      (coarse_k_o),
    .coarse_i_o      (coarse_i_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

@@ rtl/core/mvr_seq.sv @@
// Configuration registers and fine-mesh raster counters.
module mvr_seq #(
  parameter int unsigned MAX_COARSE_J = 64,
  parameter int unsigned MAX_COARSE_K = 64,
  localparam int unsigned FJ_W = $clog2(2 * MAX_COARSE_J),
  localparam int unsigned FK_W = $clog2(2 * MAX_COARSE_K)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mvr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mvr_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           acc_i,
  output logic [FJ_W-1:0]                jc_o,
  output logic [FK_W-1:0]                kc_o,
  output logic [mvr_pkg::FI_W-1:0]       ic_o,
  output mvr_pkg::step_flags_t           flags_o,
  output mvr_pkg::coarse_cfg_t           ccfg_o
);
  import mvr_pkg::*;

  logic [CFG_W-1:0]  fpj_q, fpk_q, fpi_q;
  logic [CP_W-1:0]   cpj_q, cpk_q, cpi_q;
  logic [FJ_W-1:0]   cnt_j_q, cnt_j_d;
  logic [FK_W-1:0]   cnt_k_q, cnt_k_d;
  logic [FI_W-1:0]   cnt_i_q, cnt_i_d;
  logic [CELL_W-1:0] cj, ck, ci;
  logic              j_end, k_end, i_end;
  logic              restart;

  assign cj = cell_count(fpj_q, CELL_W'(2 * MAX_COARSE_J));
  assign ck = cell_count(fpk_q, CELL_W'(2 * MAX_COARSE_K));
  assign ci = cell_count(fpi_q, CELL_W'(MAX_CELLS_I));

  assign j_end = (CELL_W'(cnt_j_q) + CELL_W'(1)) >= cj;
  assign k_end = (CELL_W'(cnt_k_q) + CELL_W'(1)) >= ck;
  assign i_end = (CELL_W'(cnt_i_q) + CELL_W'(1)) >= ci;

  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FINE_J, REG_FINE_K, REG_FINE_I,
        REG_COARSE_J, REG_COARSE_K, REG_COARSE_I: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    cnt_j_d = cnt_j_q;
    cnt_k_d = cnt_k_q;
    cnt_i_d = cnt_i_q;
    if (restart) begin
      cnt_j_d = '0;
      cnt_k_d = '0;
      cnt_i_d = '0;
    end else if (acc_i) begin
      cnt_j_d = j_end ? '0 : cnt_j_q + FJ_W'(1);
      if (j_end) begin
        cnt_k_d = k_end ? '0 : cnt_k_q + FK_W'(1);
        if (k_end) begin
          cnt_i_d = i_end ? '0 : cnt_i_q + FI_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpj_q   <= CFG_W'(17);
      fpk_q   <= CFG_W'(17);
      fpi_q   <= CFG_W'(17);
      cpj_q   <= CP_W'(9);
      cpk_q   <= CP_W'(9);
      cpi_q   <= CP_W'(9);
      cnt_j_q <= '0;
      cnt_k_q <= '0;
      cnt_i_q <= '0;
    end else begin
      cnt_j_q <= cnt_j_d;
      cnt_k_q <= cnt_k_d;
      cnt_i_q <= cnt_i_d;
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_FINE_J:   fpj_q <= cfg_wdata_i;
          REG_FINE_K:   fpk_q <= cfg_wdata_i;
          REG_FINE_I:   fpi_q <= cfg_wdata_i;
          REG_COARSE_J: cpj_q <= cfg_wdata_i[CP_W-1:0];
          REG_COARSE_K: cpk_q <= cfg_wdata_i[CP_W-1:0];
          REG_COARSE_I: cpi_q <= cfg_wdata_i[CP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign jc_o = cnt_j_q >> 1;
  assign kc_o = cnt_k_q >> 1;
  assign ic_o = cnt_i_q >> 1;

  assign flags_o.j_odd    = cnt_j_q[0];
  assign flags_o.row_go   = cnt_j_q[0] | j_end;
  assign flags_o.k_odd    = cnt_k_q[0];
  assign flags_o.plane_go = cnt_k_q[0] | k_end;
  assign flags_o.i_odd    = cnt_i_q[0];
  assign flags_o.emit     = cnt_i_q[0] | i_end;

  assign ccfg_o.cpj = cpj_q;
  assign ccfg_o.cpk = cpk_q;
  assign ccfg_o.cpi = cpi_q;

endmodule

@@ rtl/core/mvr_accum.sv @@
// Pair adder plus row and plane partial-sum memories with read-modify-write forwarding.
module mvr_accum #(
  parameter int unsigned MAX_COARSE_J = 64,
  parameter int unsigned MAX_COARSE_K = 64,
  parameter int unsigned VOLUME_BITS  = 32,
  localparam int unsigned FJ_W = $clog2(2 * MAX_COARSE_J),
  localparam int unsigned FK_W = $clog2(2 * MAX_COARSE_K)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       acc_i,
  input  logic [VOLUME_BITS-1:0]     fine_volume_i,
  input  mvr_pkg::step_flags_t       flags_i,
  input  logic [FJ_W-1:0]            jc_i,
  input  logic [FK_W-1:0]            kc_i,
  input  logic [mvr_pkg::FI_W-1:0]   ic_i,
  input  mvr_pkg::coarse_cfg_t       ccfg_i,
  output logic                       push_o,
  output logic [VOLUME_BITS+2:0]     push_vol_o,
  output mvr_pkg::res_tag_t          push_tag_o,
  output logic [1:0]                 pending_o
);
  import mvr_pkg::*;

  localparam int unsigned PW     = VOLUME_BITS + 1;
  localparam int unsigned SW     = VOLUME_BITS + 2;
  localparam int unsigned TW     = VOLUME_BITS + 3;
  localparam int unsigned PDEPTH = MAX_COARSE_J * MAX_COARSE_K;
  localparam int unsigned RAW    = (MAX_COARSE_J > 1) ? $clog2(MAX_COARSE_J) : 1;
  localparam int unsigned PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

  logic [SW-1:0] row_mem   [MAX_COARSE_J];
  logic [SW-1:0] plane_mem [PDEPTH];

  // accept stage
  logic [PW-1:0]  pair_q, pair_a;
  logic [RAW-1:0] raddr_a;
  logic [PAW-1:0] paddr_a;

  // row stage
  logic              b_valid_q;
  step_flags_t       b_flags_q;
  logic [PW-1:0]     b_pair_q;
  logic [RAW-1:0]    b_raddr_q;
  logic [PAW-1:0]    b_paddr_q;
  logic [FJ_W-1:0]   b_jc_q;
  logic [FK_W-1:0]   b_kc_q;
  logic [FI_W-1:0]   b_ic_q;
  logic [SW-1:0]     row_rd_q, row_wd_q, row_eff, rs_b;
  logic              row_fwd_q;
  logic              b_go, b_rwr;
  logic [CMP_W-1:0]  jx, kx, ix, cjx, ckx, cix;
  res_tag_t          tag_b;

  // plane stage
  logic              c_valid_q;
  logic              c_emit_q;
  logic              c_iodd_q;
  logic [SW-1:0]     c_rs_q;
  logic [PAW-1:0]    c_paddr_q;
  res_tag_t          c_tag_q;
  logic [SW-1:0]     plane_rd_q, plane_wd_q, plane_eff;
  logic              plane_fwd_q;
  logic              c_pwr;
  logic [TW-1:0]     tot_c;

  assign pair_a  = flags_i.j_odd ? pair_q + PW'(fine_volume_i) : PW'(fine_volume_i);
  assign raddr_a = jc_i[RAW-1:0];
  assign paddr_a = PAW'(kc_i * MAX_COARSE_J + jc_i);

  assign row_eff = row_fwd_q ? row_wd_q : row_rd_q;
  assign rs_b    = b_flags_q.k_odd ? row_eff + SW'(b_pair_q) : SW'(b_pair_q);
  assign b_go    = b_valid_q & b_flags_q.plane_go;
  assign b_rwr   = b_valid_q & ~b_flags_q.plane_go;

  assign jx  = CMP_W'(b_jc_q);
  assign kx  = CMP_W'(b_kc_q);
  assign ix  = CMP_W'(b_ic_q);
  assign cjx = CMP_W'(ccfg_i.cpj);
  assign ckx = CMP_W'(ccfg_i.cpk);
  assign cix = CMP_W'(ccfg_i.cpi);

  assign tag_b.jj = CP_W'(jx + CMP_W'(1));
  assign tag_b.kk = CP_W'(kx + CMP_W'(1));
  assign tag_b.ii = CP_W'(ix + CMP_W'(1));
  assign tag_b.gj = (jx + CMP_W'(2) == cjx) && (kx + CMP_W'(1) < ckx)
                 && (ix + CMP_W'(1) < cix);
  assign tag_b.gk = (kx + CMP_W'(2) == ckx) && (ix + CMP_W'(1) < cix)
                 && (jx + CMP_W'(1) <= cjx);

  assign plane_eff = plane_fwd_q ? plane_wd_q : plane_rd_q;
  assign tot_c     = c_iodd_q ? TW'(plane_eff) + TW'(c_rs_q) : TW'(c_rs_q);
  assign c_pwr     = c_valid_q & ~c_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      row_fwd_q   <= 1'b0;
      plane_fwd_q <= 1'b0;
    end else begin
      b_valid_q   <= acc_i & flags_i.row_go;
      c_valid_q   <= b_go;
      row_fwd_q   <= b_rwr & (b_raddr_q == raddr_a);
      plane_fwd_q <= c_pwr & (c_paddr_q == b_paddr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      pair_q    <= pair_a;
      b_flags_q <= flags_i;
      b_pair_q  <= pair_a;
      b_raddr_q <= raddr_a;
      b_paddr_q <= paddr_a;
      b_jc_q    <= jc_i;
      b_kc_q    <= kc_i;
      b_ic_q    <= ic_i;
    end
    row_wd_q   <= rs_b;
    plane_wd_q <= c_rs_q;
    c_emit_q   <= b_flags_q.emit;
    c_iodd_q   <= b_flags_q.i_odd;
    c_rs_q     <= rs_b;
    c_paddr_q  <= b_paddr_q;
    c_tag_q    <= tag_b;
  end

  always_ff @(posedge clk_i) begin
    if (b_rwr) begin
      row_mem[b_raddr_q] <= rs_b;
    end
    row_rd_q <= row_mem[raddr_a];
  end

  always_ff @(posedge clk_i) begin
    if (c_pwr) begin
      plane_mem[c_paddr_q] <= c_rs_q;
    end
    plane_rd_q <= plane_mem[b_paddr_q];
  end

  assign push_o     = c_valid_q & c_emit_q;
  assign push_vol_o = tot_c;
  assign push_tag_o = c_tag_q;
  assign pending_o  = {1'b0, b_go & b_flags_q.emit} + {1'b0, push_o};

endmodule

@@ rtl/core/mvr_outq.sv @@
// Result queue that expands each coarse value into its interior and ghost copies.
module mvr_outq #(
  parameter int unsigned VOLUME_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [VOLUME_BITS+2:0]      push_vol_i,
  input  mvr_pkg::res_tag_t           push_tag_i,
  input  logic [1:0]                  pending_i,
  input  mvr_pkg::coarse_cfg_t        ccfg_i,
  output logic                        stall_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [VOLUME_BITS+2:0]      coarse_volume_o,
  output logic [mvr_pkg::CP_W-1:0]    coarse_j_o,
  output logic [mvr_pkg::CP_W-1:0]    coarse_k_o,
  output logic [mvr_pkg::CP_W-1:0]    coarse_i_o,
  output logic                        last_of_run_o
);
  import mvr_pkg::*;

  logic [VOLUME_BITS+2:0] vol_q [QDEPTH];
  res_tag_t               tag_q [QDEPTH];
  logic [QPTR_W-1:0]      wptr_q, rptr_q;
  logic [QCNT_W-1:0]      count_q;
  res_sel_e               sel_q, sel_d;
  res_tag_t               head;
  logic                   take, last, pop;

  assign head = tag_q[rptr_q];

  always_comb begin
    unique case (sel_q)
      SEL_MAIN:   last = ~head.gj & ~head.gk;
      SEL_GHOSTJ: last = ~head.gk;
      SEL_GHOSTK: last = ~head.gj;
      SEL_CORNER: last = 1'b1;
      default:    last = 1'b1;
    endcase
  end

  assign out_valid_o = (count_q != '0);
  assign take        = out_valid_o & ~out_stall_i;
  assign pop         = take & last;

  always_comb begin
    sel_d = sel_q;
    if (take) begin
      if (last) begin
        sel_d = SEL_MAIN;
      end else begin
        unique case (sel_q)
          SEL_MAIN:   sel_d = head.gj ? SEL_GHOSTJ : SEL_GHOSTK;
          SEL_GHOSTJ: sel_d = SEL_GHOSTK;
          SEL_GHOSTK: sel_d = SEL_CORNER;
          default:    sel_d = SEL_MAIN;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
      sel_q   <= SEL_MAIN;
    end else begin
      sel_q   <= sel_d;
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop);
      if (push_i) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      vol_q[wptr_q] <= push_vol_i;
      tag_q[wptr_q] <= push_tag_i;
    end
  end

  assign stall_o = (count_q + QCNT_W'(pending_i)) >= QCNT_W'(QDEPTH);

  assign coarse_volume_o = vol_q[rptr_q];
  assign coarse_j_o      = (sel_q == SEL_GHOSTJ || sel_q == SEL_CORNER) ? ccfg_i.cpj : head.jj;
  assign coarse_k_o      = (sel_q == SEL_GHOSTK || sel_q == SEL_CORNER) ? ccfg_i.cpk : head.kk;
  assign coarse_i_o      = head.ii;
  assign last_of_run_o   = last;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the multigrid volume restriction block.
`timescale 1ns / 1ps

module tb;
  import mvr_pkg::*;

  localparam int unsigned COARSE_J_MAX = 64;
  localparam int unsigned COARSE_K_MAX = 64;
  localparam int unsigned RAND_ITEMS   = 300;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam logic [2:0]  REG_SPARE_LO = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [34:0] vol;
    logic [6:0]  j;
    logic [6:0]  k;
    logic [6:0]  i;
    logic        last;
  } coarse_sum_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_VOL,
    ROW_QUIET,
    ROW_CORNER
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  idx;
    logic [7:0]  data;
    logic [31:0] vol;
    logic [34:0] sum;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] fine_volume_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [34:0] coarse_volume_o;
  logic [6:0]  coarse_j_o;
  logic [6:0]  coarse_k_o;
  logic [6:0]  coarse_i_o;
  logic        last_of_run_o;

  multigrid_volume_restrict i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .fine_volume_i   (fine_volume_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .coarse_volume_o (coarse_volume_o),
    .coarse_j_o      (coarse_j_o),
    .coarse_k_o      (coarse_k_o),
    .coarse_i_o      (coarse_i_o),
    .last_of_run_o   (last_of_run_o)
  );

  // predictor state
  logic [7:0]  fine_pts [3];
  logic [6:0]  coarse_pts [3];
  int unsigned cell_cap [3] = '{2 * COARSE_J_MAX, 2 * COARSE_K_MAX, MAX_CELLS_I};
  int unsigned j_pos, k_pos, i_pos;
  logic [34:0] pair_acc;
  logic [34:0] row_acc [COARSE_J_MAX];
  logic [34:0] plane_acc [COARSE_J_MAX * COARSE_K_MAX];

  coarse_sum_t sums_due [$];
  dir_row_t    dir_tab [$];
  bit          calm;
  bit          dirty;
  int          fail_count;
  int          checked;
  int          items_sent;
  int          grid_count;

  function automatic int unsigned cells(input logic [7:0] pts, input int unsigned cap);
    int unsigned c;
    c = (pts >= 8'd2) ? int'(pts) - 1 : 1;
    return (c > cap) ? cap : c;
  endfunction

  // Folds one fine volume into the running sums; queues the coarse items it closes if keep is set.
  task automatic fold_volume(input logic [31:0] v, input bit keep);
    int unsigned cj, ck, ci, jc, kc, ic, pidx;
    int          jj, kk, ii, jl, kl, il, cpj;
    logic [34:0] pair, rows, tot;
    bit          j_done, k_done, i_done, gj, gk;
    cj = cells(fine_pts[0], cell_cap[0]);
    ck = cells(fine_pts[1], cell_cap[1]);
    ci = cells(fine_pts[2], cell_cap[2]);
    jc = j_pos / 2;
    kc = k_pos / 2;
    ic = i_pos / 2;
    pidx = kc * COARSE_J_MAX + jc;
    j_done = (j_pos % 2 == 1) || (j_pos + 1 == cj);
    k_done = (k_pos % 2 == 1) || (k_pos + 1 == ck);
    i_done = (i_pos % 2 == 1) || (i_pos + 1 == ci);
    pair = (j_pos % 2 == 1) ? pair_acc + 35'(v) : 35'(v);
    pair_acc = pair;
    if (j_done) begin
      rows = (k_pos % 2 == 1) ? row_acc[jc] + pair : pair;
      if (!k_done) begin
        row_acc[jc] = rows;
      end else begin
        tot = (i_pos % 2 == 1) ? plane_acc[pidx] + rows : rows;
        if (!i_done) begin
          plane_acc[pidx] = tot;
        end else if (keep) begin
          jj = jc + 1;
          kk = kc + 1;
          ii = ic + 1;
          cpj = int'(coarse_pts[0]);
          jl = cpj - 1;
          kl = int'(coarse_pts[1]) - 1;
          il = int'(coarse_pts[2]) - 1;
          gj = (jj == jl) && (kk <= kl) && (ii <= il);
          gk = (kk == kl) && (ii <= il) && (jj <= cpj);
          sums_due.push_back('{tot, 7'(jj), 7'(kk), 7'(ii), !(gj || gk)});
          if (gj) sums_due.push_back('{tot, coarse_pts[0], 7'(kk), 7'(ii), !gk});
          if (gk) sums_due.push_back('{tot, 7'(jj), coarse_pts[1], 7'(ii), !gj});
          if (gj && gk) sums_due.push_back('{tot, coarse_pts[0], coarse_pts[1], 7'(ii), 1'b1});
        end
      end
    end
    j_pos++;
    if (j_pos >= cj) begin
      j_pos = 0;
      k_pos++;
      if (k_pos >= ck) begin
        k_pos = 0;
        i_pos++;
        if (i_pos >= ci) i_pos = 0;
      end
    end
  endtask

  // Waits until every coarse item is out and the pipe has emptied.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    dirty = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    bit known;
    known = 1'b1;
    if (dirty) settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_FINE_J:   fine_pts[0] = val;
      REG_FINE_K:   fine_pts[1] = val;
      REG_FINE_I:   fine_pts[2] = val;
      REG_COARSE_J: coarse_pts[0] = val[6:0];
      REG_COARSE_K: coarse_pts[1] = val[6:0];
      REG_COARSE_I: coarse_pts[2] = val[6:0];
      default:      known = 1'b0;
    endcase
    if (known) begin
      j_pos = 0;
      k_pos = 0;
      i_pos = 0;
      pair_acc = '0;
    end
  endtask

  task automatic push_volume(input logic [31:0] v, input row_kind_e kind,
                             input logic [34:0] sum);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    fine_volume_i <= v;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    fold_volume(v, kind == ROW_VOL);
    if (kind == ROW_CORNER) begin
      for (int q = 0; q < 4; q++) begin
        sums_due.push_back('{sum, 7'(1 + q % 2), 7'(1 + q / 2), 7'd1, q == 3});
      end
    end
    dirty = 1'b1;
    items_sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side back-pressure
  initial begin
    int w;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      w = calm ? 0 : $urandom_range(0, 9);
      if (w != 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
    end
  end

  always @(posedge clk_i) begin
    coarse_sum_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sums_due.size() == 0) begin
        $error("unexpected coarse item: volume %h j %0d k %0d i %0d",
               coarse_volume_o, coarse_j_o, coarse_k_o, coarse_i_o);
        fail_count++;
      end else begin
        want = sums_due.pop_front();
        checked++;
        if (coarse_volume_o !== want.vol) begin
          $error("coarse_volume: expected %h, actual %h", want.vol, coarse_volume_o);
          fail_count++;
        end
        if (coarse_j_o !== want.j) begin
          $error("coarse_j: expected %0d, actual %0d", want.j, coarse_j_o);
          fail_count++;
        end
        if (coarse_k_o !== want.k) begin
          $error("coarse_k: expected %0d, actual %0d", want.k, coarse_k_o);
          fail_count++;
        end
        if (coarse_i_o !== want.i) begin
          $error("coarse_i: expected %0d, actual %0d", want.i, coarse_i_o);
          fail_count++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t    row;
    int          phase, ext, rand_items, full, n_items;
    int unsigned ncells [3];
    logic [7:0]  pts [3];
    logic [6:0]  cp [3];
    logic [31:0] v;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_FINE_J;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    fine_volume_i <= '0;
    fine_pts   = '{8'd17, 8'd17, 8'd17};
    coarse_pts = '{7'd9, 7'd9, 7'd9};
    j_pos = 0;
    k_pos = 0;
    i_pos = 0;
    pair_acc = '0;
    calm = 1'b0;

    // 2x2x2 grid, two coarse points each: every block lands on all ghost slots
    dir_tab.push_back('{ROW_WRITE, REG_FINE_J, 8'd3, 32'd0, 35'd0});
    dir_tab.push_back('{ROW_WRITE, REG_FINE_K, 8'd3, 32'd0, 35'd0});
    dir_tab.push_back('{ROW_WRITE, REG_FINE_I, 8'd3, 32'd0, 35'd0});
    dir_tab.push_back('{ROW_WRITE, REG_COARSE_J, 8'd2, 32'd0, 35'd0});
    dir_tab.push_back('{ROW_WRITE, REG_COARSE_K, 8'd2, 32'd0, 35'd0});
    dir_tab.push_back('{ROW_WRITE, REG_COARSE_I, 8'd2, 32'd0, 35'd0});
    for (int q = 0; q < 7; q++) dir_tab.push_back('{ROW_QUIET, 3'd0, 8'd0, 32'hFFFF_FFFF, 35'd0});
    dir_tab.push_back('{ROW_CORNER, 3'd0, 8'd0, 32'hFFFF_FFFF, 35'h7_FFFF_FFF8});
    for (int q = 0; q < 7; q++) dir_tab.push_back('{ROW_QUIET, 3'd0, 8'd0, 32'd0, 35'd0});
    dir_tab.push_back('{ROW_CORNER, 3'd0, 8'd0, 32'd0, 35'd0});
    // planar, odd j cell count, k below two points
    dir_tab.push_back('{ROW_WRITE, REG_FINE_I, 8'd1, 32'd0, 35'd0});
    dir_tab.push_back('{ROW_WRITE, REG_FINE_J, 8'd4, 32'd0, 35'd0});
    dir_tab.push_back('{ROW_WRITE, REG_FINE_K, 8'd0, 32'd0, 35'd0});
    dir_tab.push_back('{ROW_VOL, 3'd0, 8'd0, 32'h0001_0000, 35'd0});
    dir_tab.push_back('{ROW_VOL, 3'd0, 8'd0, 32'h0002_0000, 35'd0});
    dir_tab.push_back('{ROW_VOL, 3'd0, 8'd0, 32'h8000_0001, 35'd0});
    // writes past the register list must not restart the stream
    dir_tab.push_back('{ROW_VOL, 3'd0, 8'd0, 32'h1234_5678, 35'd0});
    dir_tab.push_back('{ROW_WRITE, REG_SPARE_HI, 8'hFF, 32'd0, 35'd0});
    dir_tab.push_back('{ROW_WRITE, REG_SPARE_LO, 8'h00, 32'd0, 35'd0});
    dir_tab.push_back('{ROW_VOL, 3'd0, 8'd0, 32'h0000_FFFF, 35'd0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[q]) begin
      row = dir_tab[q];
      if (row.kind == ROW_WRITE) write_reg(row.idx, row.data);
      else push_volume(row.vol, row.kind, row.sum);
    end
    grid_count = 2;

    // phases 1, 3 and 5 take one direction past the cell clamp
    rand_items = 0;
    for (phase = 0; phase < 6 || rand_items < RAND_ITEMS; phase++) begin
      ext = (phase == 1) ? 0 : (phase == 3) ? 1 : (phase == 5) ? 2 : -1;
      for (int d = 0; d < 3; d++) begin
        if (d == ext)    pts[d] = 8'($urandom_range(129, 255));
        else if (ext >= 0) pts[d] = 8'($urandom_range(0, 2));
        else             pts[d] = 8'($urandom_range(0, 5));
        ncells[d] = cells(pts[d], cell_cap[d]);
        cp[d] = ($urandom_range(0, 3) != 0) ? 7'((ncells[d] + 1) / 2 + 1 + $urandom_range(0, 1))
                                            : 7'($urandom_range(0, 127));
      end
      write_reg(REG_FINE_J, pts[0]);
      write_reg(REG_FINE_K, pts[1]);
      write_reg(REG_FINE_I, pts[2]);
      if ($urandom_range(0, 1)) write_reg(REG_COARSE_J, {1'($urandom_range(0, 1)), cp[0]});
      if ($urandom_range(0, 1)) write_reg(REG_COARSE_K, {1'($urandom_range(0, 1)), cp[1]});
      if ($urandom_range(0, 1)) write_reg(REG_COARSE_I, {1'($urandom_range(0, 1)), cp[2]});
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 8'($urandom));
      grid_count++;

      full = ncells[0] * ncells[1] * ncells[2];
      if ($urandom_range(0, 3) == 0) n_items = $urandom_range(1, full);
      else n_items = full * ((ext >= 0) ? 1 : $urandom_range(1, 2));
      calm = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < n_items; n++) begin
        v = $urandom;
        case ($urandom_range(0, 7))
          0: v = '0;
          1: v = '1;
          default: ;
        endcase
        push_volume(v, ROW_VOL, '0);
        rand_items++;
      end
    end

    settle();
    $display("Streamed %0d fine volumes over %0d grid settings, %0d coarse items checked",
             items_sent, grid_count, checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
